// File: src/pmst_pkg.sv
`default_nettype none

package pmst_pkg;

	// width of the vertex count configuration word
	localparam int CFG_BITS = 7;

	// controller states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_START,
		ST_PASS,
		ST_DRAIN,
		ST_SELECT,
		ST_OUT_RD,
		ST_OUT_LOAD
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load_we;
		logic run_init;
		logic pass_issue;
		logic sel_next;
		logic out_rd;
		logic out_load;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic load_done;
		logic j_last;
		logic found;
		logic last_pass;
		logic c_last;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// File: src/pmst_ctrl.sv
`default_nettype none

module pmst_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  pmst_pkg::status_t status,
	output logic              in_stall,
	output pmst_pkg::cmd_t    cmd
);
	import pmst_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_valid && status.load_done) state_d = ST_START;
			end
			ST_START: begin
				state_d = ST_PASS;
			end
			ST_PASS: begin
				if (status.j_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_SELECT;
			end
			ST_SELECT: begin
				if (status.found && !status.last_pass) state_d = ST_PASS;
				else state_d = ST_OUT_RD;
			end
			ST_OUT_RD: begin
				state_d = ST_OUT_LOAD;
			end
			ST_OUT_LOAD: begin
				if (status.out_free) begin
					if (status.c_last) state_d = ST_LOAD;
					else state_d = ST_OUT_RD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// command outputs
	always_comb begin
		in_stall       = (state_q != ST_LOAD);
		cmd            = '0;
		cmd.load_we    = (state_q == ST_LOAD) && in_valid;
		cmd.run_init   = (state_q == ST_START);
		cmd.pass_issue = (state_q == ST_PASS);
		cmd.sel_next   = (state_q == ST_SELECT) && status.found && !status.last_pass;
		cmd.out_rd     = (state_q == ST_OUT_RD);
		cmd.out_load   = (state_q == ST_OUT_LOAD) && status.out_free;
	end

endmodule

`default_nettype wire

// File: src/pmst_datapath.sv
`default_nettype none

module pmst_datapath #(
	parameter int MAX_VERTICES = 64,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pmst_pkg::cmd_t                      cmd,
	output pmst_pkg::status_t                   status,
	input  logic                                cfg_we,
	input  logic [pmst_pkg::CFG_BITS-1:0]       cfg_wdata,
	input  logic [WEIGHT_BITS-1:0]              edge_weight,
	input  logic                                no_edge,
	input  logic                                out_stall,
	output logic                                out_valid,
	output logic [$clog2(MAX_VERTICES)-1:0]     parent_vertex,
	output logic [$clog2(MAX_VERTICES)-1:0]     child_vertex,
	output logic [WEIGHT_BITS-1:0]              tree_weight,
	output logic                                unreachable,
	output logic                                last
);
	import pmst_pkg::*;

	localparam int VW    = $clog2(MAX_VERTICES);
	localparam int NW    = $clog2(MAX_VERTICES + 1);
	localparam int LW    = (CFG_BITS > NW) ? CFG_BITS : NW;
	localparam int KW    = WEIGHT_BITS + 1;
	localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [KW-1:0] KEY_INF = KW'(1) << WEIGHT_BITS;

	// vertex count and load position
	logic [NW-1:0] n_q;
	logic [NW-1:0] n_d;
	logic [LW-1:0] cfg_ext;
	logic [VW-1:0] row_q;
	logic [VW-1:0] col_q;
	logic          row_end;
	logic          col_end;

	// prim pass control
	logic [VW-1:0]           j_q;
	logic [VW-1:0]           k_q;
	logic [VW-1:0]           c_q;
	logic [VW-1:0]           pass_cnt_q;
	logic                    first_q;
	logic [MAX_VERTICES-1:0] in_tree_q;
	logic [KW-1:0]           min_key_q;
	logic [VW-1:0]           min_idx_q;
	logic                    found_q;

	// memories
	logic [KW-1:0] wmem [DEPTH];
	logic [KW-1:0] key_mem [MAX_VERTICES];
	logic [VW-1:0] parent_mem [MAX_VERTICES];
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [VW-1:0] key_raddr;

	// stage one of the relax pipeline
	logic                   v_s1;
	logic [VW-1:0]          j_s1;
	logic [KW-1:0]          wrd_s1;
	logic [KW-1:0]          key_s1;
	logic [VW-1:0]          par_rd_q;
	logic [WEIGHT_BITS-1:0] w_s1;
	logic                   intree_s1;
	logic [KW-1:0]          old_key;
	logic                   upd;
	logic [KW-1:0]          key_new;

	// output register
	logic                   out_valid_q;
	logic [VW-1:0]          parent_q;
	logic [VW-1:0]          child_q;
	logic [WEIGHT_BITS-1:0] weight_q;
	logic                   unr_q;
	logic                   last_q;
	logic                   out_free;

	// clamp the written vertex count into the supported range
	always_comb begin
		cfg_ext = LW'(cfg_wdata);
		if (cfg_ext < LW'(2)) n_d = NW'(2);
		else if (cfg_ext > LW'(MAX_VERTICES)) n_d = NW'(MAX_VERTICES);
		else n_d = NW'(cfg_ext);
	end

	assign row_end = (NW'(row_q) == n_q - NW'(1));
	assign col_end = (NW'(col_q) == n_q - NW'(1));

	// vertex count register and row-major load position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= NW'(2);
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_we) begin
			n_q   <= n_d;
			row_q <= '0;
			col_q <= '0;
		end else if (cmd.load_we) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + VW'(1);
			end else begin
				col_q <= col_q + VW'(1);
			end
		end
	end

	// weight matrix memory, rows at a fixed stride
	assign waddr = AW'(row_q) * AW'(MAX_VERTICES) + AW'(col_q);
	assign raddr = AW'(k_q) * AW'(MAX_VERTICES) + AW'(j_q);

	always_ff @(posedge clk) begin
		if (cmd.load_we) wmem[waddr] <= {no_edge, edge_weight};
		if (cmd.pass_issue) wrd_s1 <= wmem[raddr];
	end

	// key and parent memories
	assign key_raddr = cmd.out_rd ? c_q : j_q;

	always_ff @(posedge clk) begin
		if (cmd.pass_issue || cmd.out_rd) key_s1 <= key_mem[key_raddr];
		if (cmd.out_rd) par_rd_q <= parent_mem[c_q];
		if (v_s1) key_mem[j_s1] <= key_new;
		if (v_s1 && upd) parent_mem[j_s1] <= k_q;
	end

	// relax one vertex against the row of the newest tree vertex
	always_comb begin
		w_s1      = wrd_s1[WEIGHT_BITS-1:0];
		intree_s1 = in_tree_q[j_s1];
		old_key   = first_q ? KEY_INF : key_s1;
		upd       = !wrd_s1[WEIGHT_BITS] && (w_s1 != '0) && !intree_s1
			&& ({1'b0, w_s1} < old_key);
		key_new   = upd ? {1'b0, w_s1} : old_key;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.pass_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pass_issue) j_s1 <= j_q;
	end

	// pass sequencing, tree membership and minimum search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q        <= '0;
			k_q        <= '0;
			c_q        <= '0;
			pass_cnt_q <= '0;
			first_q    <= 1'b0;
			in_tree_q  <= '0;
			min_key_q  <= KEY_INF;
			min_idx_q  <= '0;
			found_q    <= 1'b0;
		end else begin
			if (cmd.run_init) begin
				j_q        <= '0;
				k_q        <= '0;
				c_q        <= VW'(1);
				pass_cnt_q <= '0;
				first_q    <= 1'b1;
				in_tree_q  <= MAX_VERTICES'(1);
				min_key_q  <= KEY_INF;
				found_q    <= 1'b0;
			end else if (cmd.sel_next) begin
				j_q                  <= '0;
				k_q                  <= min_idx_q;
				pass_cnt_q           <= pass_cnt_q + VW'(1);
				first_q              <= 1'b0;
				in_tree_q[min_idx_q] <= 1'b1;
				min_key_q            <= KEY_INF;
				found_q              <= 1'b0;
			end else begin
				if (cmd.pass_issue) j_q <= j_q + VW'(1);
				if (v_s1 && !intree_s1 && (key_new < min_key_q)) begin
					min_key_q <= key_new;
					min_idx_q <= j_s1;
					found_q   <= 1'b1;
				end
				if (cmd.out_load && !status.c_last) c_q <= c_q + VW'(1);
			end
		end
	end

	// result register
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			unr_q    <= key_s1[WEIGHT_BITS];
			parent_q <= key_s1[WEIGHT_BITS] ? '0 : par_rd_q;
			weight_q <= key_s1[WEIGHT_BITS] ? '0 : key_s1[WEIGHT_BITS-1:0];
			child_q  <= c_q;
			last_q   <= status.c_last;
		end
	end

	// status to the controller
	always_comb begin
		status           = '0;
		status.load_done = row_end && col_end;
		status.j_last    = (NW'(j_q) == n_q - NW'(1));
		status.found     = found_q;
		status.last_pass = (NW'(pass_cnt_q) == n_q - NW'(2));
		status.c_last    = (NW'(c_q) == n_q - NW'(1));
		status.out_free  = out_free;
	end

	assign out_valid     = out_valid_q;
	assign parent_vertex = parent_q;
	assign child_vertex  = child_q;
	assign tree_weight   = weight_q;
	assign unreachable   = unr_q;
	assign last          = last_q;

endmodule

`default_nettype wire

// File: src/prim_minimum_spanning_tree.sv
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  edge_weight, no_edge
// out       output     out_valid/out_stall  parent_vertex, child_vertex, tree_weight,
//                                           unreachable, last
// cfg       input      cfg_we               cfg_wdata (vertex count)
//
// Loading writes one matrix entry per cycle into the weight memory, n*n entries in all.
// The tree search then runs up to n-1 passes, one per tree vertex but the last one added,
// each scanning one row through the single read port of the weight memory.
// Each of the n-1 results then takes a key/parent read and an output load, plus stalls.
// Reset clears all control state; no clearing pass over the memories is needed.
// in_stall is high from the last matrix entry until the final result is loaded.
`default_nettype none

module prim_minimum_spanning_tree #(
	parameter int MAX_VERTICES = 64,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pmst_pkg::CFG_BITS-1:0]   cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [WEIGHT_BITS-1:0]          edge_weight,
	input  logic                            no_edge,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [$clog2(MAX_VERTICES)-1:0] parent_vertex,
	output logic [$clog2(MAX_VERTICES)-1:0] child_vertex,
	output logic [WEIGHT_BITS-1:0]          tree_weight,
	output logic                            unreachable,
	output logic                            last
);
	import pmst_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencer
	pmst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// memories, counters and relax logic
	pmst_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.edge_weight   (edge_weight),
		.no_edge       (no_edge),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.parent_vertex (parent_vertex),
		.child_vertex  (child_vertex),
		.tree_weight   (tree_weight),
		.unreachable   (unreachable),
		.last          (last)
	);

endmodule

`default_nettype wire

// File: src/pmst_checker.sv
`default_nettype none

module pmst_checker #(
	parameter int MAX_VERTICES = 64,
	parameter int WEIGHT_BITS  = 16
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [$clog2(MAX_VERTICES)-1:0] parent_vertex,
	input logic [$clog2(MAX_VERTICES)-1:0] child_vertex,
	input logic [WEIGHT_BITS-1:0]          tree_weight,
	input logic                            unreachable,
	input logic                            last
);

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(parent_vertex)
			&& $stable(child_vertex) && $stable(tree_weight)
			&& $stable(unreachable) && $stable(last))
		else $error("stalled result item changed");

	// an unreachable child carries no parent and no weight
	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unreachable |-> parent_vertex == '0 && tree_weight == '0)
		else $error("unreachable item with parent or weight");

	// a tree edge joins two distinct vertices with a nonzero weight
	a_edge_sane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !unreachable |-> tree_weight != '0 && parent_vertex != child_vertex
			&& child_vertex != '0)
		else $error("malformed tree edge");

	// a new run needs a full matrix load, so nothing follows the final edge at once
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last |=> !out_valid)
		else $error("result item right after final edge");

endmodule

bind prim_minimum_spanning_tree pmst_checker #(
	.MAX_VERTICES (MAX_VERTICES),
	.WEIGHT_BITS  (WEIGHT_BITS)
) u_pmst_checker (.*);

`default_nettype wire
